[sv/mmu_pkg.sv]
package mmu_pkg;

	localparam int DATA_BITS = 64;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NEG_INVERSE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_R_SQUARED   = 2'd2;

	typedef enum logic [1:0] {
		ACT_REDUCE    = 2'd0,
		ACT_TO_MONT   = 2'd1,
		ACT_FROM_MONT = 2'd2,
		ACT_MULTIPLY  = 2'd3
	} action_t;

endpackage

[sv/montgomery_modmul_unit.sv]
// Montgomery multiply and reduce unit, R = 2^WORD_BITS.
// Configuration: cfg_write with cfg_index and cfg_data loads modulus (0),
// neg_inverse (1) or r_squared (2); other indexes are ignored.
// Write registers only while no item is in flight.
// Items: an item is taken on every rising edge with start high and busy low;
// busy is always low, so one item may enter every cycle.
// Actions: reduce (operand_a high word, operand_b low word), to Montgomery
// form (operand_a times r_squared), from Montgomery form (operand_a alone),
// multiply (operand_a times operand_b); each ends in one REDC pass.
// Output: result and done appear together when the item leaves the last
// register stage; one result per item, in order.
// The path is nine register stages, the first loaded at the taking edge:
// three two-stage half-word multipliers (product, reduction factor, factor
// times modulus) and a three-stage add and correction tail. Throughput is
// one item per cycle.
// Results are shown for one cycle only; the receiver cannot stall them.
// Reset clears the in-flight valid bits and sets the modulus to 1 and the
// other configuration registers to 0; items in flight at reset are dropped.
module montgomery_modmul_unit #(
	parameter int WORD_BITS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [mmu_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [mmu_pkg::DATA_BITS-1:0]        cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  mmu_pkg::action_t                     action,
	input  logic [mmu_pkg::DATA_BITS-1:0]        operand_a,
	input  logic [mmu_pkg::DATA_BITS-1:0]        operand_b,
	output logic [mmu_pkg::DATA_BITS-1:0]        result,
	output logic                                 done
);
	import mmu_pkg::*;

	localparam int W   = WORD_BITS;
	localparam int LAT = 9;

	logic [W-1:0]   modulus_q;
	logic [W-1:0]   neg_inverse_q;
	logic [W-1:0]   r_squared_q;
	logic [LAT-1:0] valid_q;

	logic [W-1:0] a_in;
	logic [W-1:0] y_in;
	action_t      act_s1;
	action_t      act_s2;
	logic [W-1:0] a_s1;
	logic [W-1:0] a_s2;
	logic [W-1:0] b_s1;
	logic [W-1:0] b_s2;
	logic [W-1:0] p_hi;
	logic [W-1:0] p_lo;
	logic [W-1:0] t_hi;
	logic [W-1:0] t_lo;
	logic [W-1:0] t_hi_s3;
	logic [W-1:0] t_lo_s3;
	logic [W-1:0] t_hi_s4;
	logic [W-1:0] t_lo_s4;
	logic [W-1:0] t_hi_s5;
	logic [W-1:0] t_lo_s5;
	logic [W-1:0] t_hi_s6;
	logic [W-1:0] t_lo_s6;
	logic [W-1:0] m_unused;
	logic [W-1:0] m_word;
	logic [W-1:0] mp_hi;
	logic [W-1:0] mp_lo;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q     <= W'(1);
			neg_inverse_q <= '0;
			r_squared_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MODULUS:     modulus_q     <= cfg_data[W-1:0];
				CFG_NEG_INVERSE: neg_inverse_q <= cfg_data[W-1:0];
				CFG_R_SQUARED:   r_squared_q   <= cfg_data[W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[LAT-2:0], start & ~busy};
		end
	end

	assign done = valid_q[LAT-1];

	// product of the operands
	assign a_in = operand_a[W-1:0];
	assign y_in = (action == ACT_TO_MONT) ? r_squared_q : operand_b[W-1:0];

	mmu_mul #(.W(W)) u_mul_ab (
		.clk     (clk),
		.x       (a_in),
		.y       (y_in),
		.prod_hi (p_hi),
		.prod_lo (p_lo)
	);

	always_ff @(posedge clk) begin
		act_s1 <= action;
		a_s1   <= a_in;
		b_s1   <= operand_b[W-1:0];
		act_s2 <= act_s1;
		a_s2   <= a_s1;
		b_s2   <= b_s1;
	end

	// double word to reduce
	always_comb begin
		case (act_s2)
			ACT_REDUCE: begin
				t_hi = a_s2;
				t_lo = b_s2;
			end
			ACT_FROM_MONT: begin
				t_hi = '0;
				t_lo = a_s2;
			end
			default: begin
				t_hi = p_hi;
				t_lo = p_lo;
			end
		endcase
	end

	mmu_mul #(.W(W)) u_mul_m (
		.clk     (clk),
		.x       (t_lo),
		.y       (neg_inverse_q),
		.prod_hi (m_unused),
		.prod_lo (m_word)
	);

	mmu_mul #(.W(W)) u_mul_mp (
		.clk     (clk),
		.x       (m_word),
		.y       (modulus_q),
		.prod_hi (mp_hi),
		.prod_lo (mp_lo)
	);

	always_ff @(posedge clk) begin
		t_hi_s3 <= t_hi;
		t_lo_s3 <= t_lo;
		t_hi_s4 <= t_hi_s3;
		t_lo_s4 <= t_lo_s3;
		t_hi_s5 <= t_hi_s4 ^ (m_unused & '0);
		t_lo_s5 <= t_lo_s4;
		t_hi_s6 <= t_hi_s5;
		t_lo_s6 <= t_lo_s5;
	end

	mmu_tail #(.W(W)) u_tail (
		.clk     (clk),
		.t_hi    (t_hi_s6),
		.t_lo    (t_lo_s6),
		.m_hi    (mp_hi),
		.m_lo    (mp_lo),
		.modulus (modulus_q),
		.result  (result)
	);

endmodule

[sv/mmu_mul.sv]
module mmu_mul #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	output logic [W-1:0] prod_hi,
	output logic [W-1:0] prod_lo
);
	import mmu_pkg::*;

	localparam int HB = (W + 1) / 2;

	logic [2*HB-1:0] xe;
	logic [2*HB-1:0] ye;
	logic [2*HB-1:0] pp00_s1;
	logic [2*HB-1:0] pp01_s1;
	logic [2*HB-1:0] pp10_s1;
	logic [2*HB-1:0] pp11_s1;
	logic [4*HB-1:0] full;
	logic [W-1:0]    hi_s2;
	logic [W-1:0]    lo_s2;

	assign xe = (2*HB)'(x);
	assign ye = (2*HB)'(y);

	// half-word partial products
	always_ff @(posedge clk) begin
		pp00_s1 <= xe[HB-1:0] * ye[HB-1:0];
		pp01_s1 <= xe[HB-1:0] * ye[2*HB-1:HB];
		pp10_s1 <= xe[2*HB-1:HB] * ye[HB-1:0];
		pp11_s1 <= xe[2*HB-1:HB] * ye[2*HB-1:HB];
	end

	assign full = {pp11_s1, pp00_s1}
		+ ((4*HB)'(pp01_s1) << HB)
		+ ((4*HB)'(pp10_s1) << HB);

	always_ff @(posedge clk) begin
		hi_s2 <= full[2*W-1:W];
		lo_s2 <= full[W-1:0];
	end

	assign prod_hi = hi_s2;
	assign prod_lo = lo_s2;

endmodule

[sv/mmu_tail.sv]
module mmu_tail #(
	parameter int W = 64
) (
	input  logic                           clk,
	input  logic [W-1:0]                   t_hi,
	input  logic [W-1:0]                   t_lo,
	input  logic [W-1:0]                   m_hi,
	input  logic [W-1:0]                   m_lo,
	input  logic [W-1:0]                   modulus,
	output logic [mmu_pkg::DATA_BITS-1:0]  result
);
	import mmu_pkg::*;

	logic [W:0]   lo_sum;
	logic         carry_s1;
	logic [W:0]   hsum_s1;
	logic [W:0]   top_s2;
	logic         over;
	logic [W-1:0] res_s3;

	assign lo_sum = (W+1)'(t_lo) + (W+1)'(m_lo);

	// carry out of the low word, sum of high words
	always_ff @(posedge clk) begin
		carry_s1 <= lo_sum[W];
		hsum_s1  <= (W+1)'(t_hi) + (W+1)'(m_hi);
	end

	always_ff @(posedge clk) begin
		top_s2 <= hsum_s1 + (W+1)'(carry_s1);
	end

	// one conditional subtraction
	assign over = top_s2[W] || (top_s2[W-1:0] >= modulus);

	always_ff @(posedge clk) begin
		res_s3 <= over ? (top_s2[W-1:0] - modulus) : top_s2[W-1:0];
	end

	assign result = DATA_BITS'(res_s3);

endmodule
